>>> sv/rbsf_pkg.sv
`timescale 1ns / 1ps

package rbsf_pkg;

  // Defaults
  localparam int MAX_SIDE_DEF = 1024;
  localparam int SIDE_RESET   = 512;

  // Field widths
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int CFG_W = 11;

  // Configuration register indexes
  localparam logic CFG_SIDE = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  // Filter modes
  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  // ceil(2^16 / 9): exact floor division for sums up to 9 * 255
  localparam logic [13:0] RECIP9 = 14'd7282;

  typedef logic [8:0][CH_W-1:0] chan_win_t;

  // Filter one channel of a 3x3 window (entry 4 is the center)
  function automatic logic [CH_W-1:0] filt_chan(input chan_win_t w, input logic mode);
    logic [11:0]        sum;
    logic [25:0]        prod;
    logic signed [13:0] shp;
    logic [CH_W-1:0]    res;
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      sum = sum + 12'(w[k]);
    end
    prod = 26'(sum) * 26'(RECIP9);
    // ten times center minus the whole sum = nine center minus neighbors
    shp  = $signed({2'b00, 12'(w[4]) * 12'd10}) - $signed({2'b00, sum});
    if (mode == MODE_BLUR) begin
      res = prod[23:16];
    end else if (shp < 14'sd0) begin
      res = '0;
    end else if (shp > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = shp[7:0];
    end
    return res;
  endfunction

endpackage

>>> sv/rgb_3x3_blur_sharpen_filter_unit.sv
`timescale 1ns / 1ps

// 3x3 box blur / sharpen filter for RGB pixels of a square image in raster
// order. One request is taken per clock; the result for a pixel leaves with
// the request that comes image_side+1 places after it, so a frame is closed
// by image_side+1 drain requests (tuser high), and the last result carries
// tlast. Border pixels pass unchanged; interior pixels get floor(sum/9) in
// blur mode or 9*center minus neighbors, clamped to 0..255, in sharpen mode.
// Inside, a request waits in an input stage while both line buffers
// are read, then updates the window and lands in the output register, which
// frees the input stage so a new request enters every cycle unless the output
// register is held. Drain requests before the frame is complete are taken and
// dropped. Line buffers need no clearing pass; write image_side and
// filter_mode only while the block is idle. Writing image_side starts a frame.
module rgb_3x3_blur_sharpen_filter_unit #(
  parameter int MAX_SIDE = rbsf_pkg::MAX_SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rbsf_pkg::PIX_W-1:0] in_tdata,   // red_in, green_in, blue_in
  input  logic                       in_tuser,   // req_type
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rbsf_pkg::PIX_W-1:0] out_tdata,  // red_out, green_out, blue_out
  output logic                       out_tlast,  // frame_last
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [rbsf_pkg::CFG_W-1:0] cfg_data
);
  import rbsf_pkg::*;

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = $clog2(MAX_SIDE);
  localparam int RW = $clog2(MAX_SIDE + 2);
  localparam int SIDE_INIT = (SIDE_RESET < MAX_SIDE) ? SIDE_RESET : MAX_SIDE;

  // configuration
  logic [SW-1:0] side_r;
  logic          mode_r;
  logic [SW-1:0] side_wr;
  logic [SW-1:0] side_m1;
  logic          cfg_fire;
  logic          side_wr_en;

  // frame position of the next request and of the next result
  logic [CW-1:0] in_col_r;
  logic [RW-1:0] in_row_r;
  logic [CW-1:0] out_col_r;
  logic [CW-1:0] out_row_r;

  // input stage
  logic             a_valid_r;
  logic [PIX_W-1:0] a_px_r;
  logic [CW-1:0]    a_col_r;
  logic             a_emit_r;
  logic             a_inner_r;
  logic             a_last_r;
  logic             a_fire;

  // line buffers, read data and same-address forwarding
  logic [PIX_W-1:0] line_a [MAX_SIDE];
  logic [PIX_W-1:0] line_b [MAX_SIDE];
  logic [PIX_W-1:0] rd_a_r;
  logic [PIX_W-1:0] rd_b_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_a_r;
  logic [PIX_W-1:0] fwd_b_r;
  logic [PIX_W-1:0] a_eff;
  logic [PIX_W-1:0] b_eff;

  // window
  logic [PIX_W-1:0] win_r   [9];
  logic [PIX_W-1:0] win_nxt [9];

  // output register
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;
  logic [PIX_W-1:0] res_px;

  // request decode
  logic             in_fire;
  logic             has_px;
  logic             drop;
  logic             load;
  logic             emit;
  logic             col_wrap;
  logic             q_last;
  logic             q_inner;
  logic             q_col_wrap;
  logic [PIX_W-1:0] in_px;

  // Clamp a written side into 1..MAX_SIDE
  always_comb begin
    if (cfg_data == '0) begin
      side_wr = SW'(1);
    end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
      side_wr = SW'(MAX_SIDE);
    end else begin
      side_wr = SW'(cfg_data);
    end
  end

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign side_wr_en = cfg_fire && (cfg_index == CFG_SIDE);
  assign side_m1    = side_r - SW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SW'(SIDE_INIT);
      mode_r <= MODE_BLUR;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_SIDE: side_r <= side_wr;
        CFG_MODE: mode_r <= cfg_data[0];
        default:  side_r <= side_r;
      endcase
    end
  end

  // Decode the incoming request against the frame position
  assign in_fire    = in_tvalid && in_tready;
  assign has_px     = 32'(in_row_r) < 32'(side_r);
  assign drop       = has_px && in_tuser;
  assign load       = in_fire && !drop;
  assign emit       = !((in_row_r == '0) || ((in_row_r == RW'(1)) && (in_col_r == '0)));
  assign col_wrap   = 32'(in_col_r) == 32'(side_m1);
  assign q_col_wrap = 32'(out_col_r) == 32'(side_m1);
  assign q_last     = (32'(out_row_r) == 32'(side_m1)) && q_col_wrap;
  assign q_inner    = (out_row_r != '0) && (32'(out_row_r) != 32'(side_m1))
                   && (out_col_r != '0) && !q_col_wrap;
  assign in_px      = has_px ? {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]} : '0;

  // Advance frame counters; restart on a side write or after the last result
  always_ff @(posedge clk) begin
    if (!rst_n || side_wr_en) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (load) begin
      if (emit && q_last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        in_col_r <= col_wrap ? '0 : in_col_r + CW'(1);
        in_row_r <= col_wrap ? in_row_r + RW'(1) : in_row_r;
        if (emit) begin
          out_col_r <= q_col_wrap ? '0 : out_col_r + CW'(1);
          out_row_r <= q_col_wrap ? out_row_r + CW'(1) : out_row_r;
        end
      end
    end
  end

  // Input stage handshake
  assign a_fire    = a_valid_r && (!a_emit_r || !out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (load) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  // Capture request payload and same-cycle write-back forwarding
  always_ff @(posedge clk) begin
    if (load) begin
      a_px_r    <= in_px;
      a_col_r   <= in_col_r;
      a_emit_r  <= emit;
      a_inner_r <= q_inner;
      a_last_r  <= q_last;
      fwd_r     <= a_fire && (a_col_r == in_col_r);
      fwd_a_r   <= a_px_r;
      fwd_b_r   <= a_eff;
    end
  end

  // Line buffers: read on load, shift rows down on fire
  always_ff @(posedge clk) begin
    if (a_fire) begin
      line_a[a_col_r] <= a_px_r;
      line_b[a_col_r] <= a_eff;
    end
    if (load) begin
      rd_a_r <= line_a[in_col_r];
      rd_b_r <= line_b[in_col_r];
    end
  end

  assign a_eff = fwd_r ? fwd_a_r : rd_a_r;
  assign b_eff = fwd_r ? fwd_b_r : rd_b_r;

  // Shift the window one column and pull in the new column
  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = b_eff;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = a_eff;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = a_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (a_fire) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // Filter interior pixels per channel, pass border pixels
  always_comb begin
    chan_win_t wr;
    chan_win_t wg;
    chan_win_t wb;
    for (int k = 0; k < 9; k++) begin
      wr[k] = win_nxt[k][23:16];
      wg[k] = win_nxt[k][15:8];
      wb[k] = win_nxt[k][7:0];
    end
    if (a_inner_r) begin
      res_px = {filt_chan(wr, mode_r), filt_chan(wg, mode_r), filt_chan(wb, mode_r)};
    end else begin
      res_px = win_nxt[4];
    end
  end

  // Output register
  always_comb begin
    if (a_fire && a_emit_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_emit_r) begin
      out_data_r <= {res_px[7:0], res_px[15:8], res_px[23:16]};
      out_last_r <= a_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
